// ===== rtl/rkg_pkg.sv =====
// Package: constants, state encoding and controller/datapath structs for the group reverser
package rkg_pkg;

    localparam int MAX_GROUP = 16;
    localparam int VAL_W     = 32;
    localparam int GS_W      = 5;
    localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int CMP_W     = (CNT_W > GS_W) ? CNT_W : GS_W;
    localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic accept;
        logic read;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic run_end;
    } t_status;

endpackage

// ===== rtl/rkg_in_if.sv =====
// Interface: input request channel (value with end-of-list flag)
interface rkg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rkg_pkg::VAL_W-1:0]    value;
    logic                                end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

// ===== rtl/rkg_out_if.sv =====
// Interface: output request channel (reordered value with run and list markers)
interface rkg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rkg_pkg::VAL_W-1:0]    out_value;
    logic                                last_of_run;
    logic                                list_done;

    modport source (output valid, output out_value, output last_of_run, output list_done,
                    input ready);
    modport sink   (input valid, input out_value, input last_of_run, input list_done,
                    output ready);
endinterface

// ===== rtl/block_reverse_k_group.sv =====
// Top level: reverses a value stream in groups of group_size
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        value[31:0] signed, end_of_list
//  o_out     out  valid/ready        out_value[31:0] signed, last_of_run, list_done
//  cfg       in   i_cfg_we           i_cfg_data[4:0] = group_size
//
// An input request that closes a run goes to a buffer fetch state, then one
// result per cycle while o_out is ready; a short group closed by end_of_list
// is sent in order. One group buffer read per result paces the drain.
// Input is held off while a run drains. Synchronous active-low reset clears the
// fill count and sets group_size to 1; no clearing pass is needed.
module block_reverse_k_group (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rkg_pkg::GS_W-1:0]  i_cfg_data,
    rkg_in_if.sink                    i_in,
    rkg_out_if.source                 o_out
);
    rkg_pkg::t_cmd    w_cmd;
    rkg_pkg::t_status w_status;
    logic             w_in_ready;
    logic             w_out_valid;

    rkg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    rkg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_value       (i_in.value),
        .i_end_of_list (i_in.end_of_list),
        .o_status      (w_status),
        .o_out_value   (o_out.out_value),
        .o_last_of_run (o_out.last_of_run),
        .o_list_done   (o_out.list_done)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
endmodule

// ===== rtl/rkg_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rkg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rkg_ctrl.sv =====
// Controller: accept, fetch and send sequencing for one run of results
module rkg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  rkg_pkg::t_status i_status,
    output rkg_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    rkg_pkg::t_state r_state;
    rkg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rkg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        case (r_state)
            rkg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.emit) begin
                        n_state = rkg_pkg::ST_FETCH;
                    end
                end
            end
            rkg_pkg::ST_FETCH: begin
                o_cmd.read = 1'b1;
                n_state    = rkg_pkg::ST_SEND;
            end
            rkg_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.run_end) begin
                        n_state = rkg_pkg::ST_IDLE;
                    end else begin
                        o_cmd.read = 1'b1;
                    end
                end
            end
            default: begin
                n_state = rkg_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/rkg_dp.sv =====
// Datapath: group buffer, fill count, group size register and read sequencing
module rkg_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rkg_pkg::GS_W-1:0]          i_cfg_data,
    input  rkg_pkg::t_cmd                     i_cmd,
    input  logic signed [rkg_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_end_of_list,
    output rkg_pkg::t_status                  o_status,
    output logic signed [rkg_pkg::VAL_W-1:0]  o_out_value,
    output logic                              o_last_of_run,
    output logic                              o_list_done
);
    logic [rkg_pkg::GS_W-1:0]   r_gs;
    logic [rkg_pkg::CNT_W-1:0]  r_fill;
    logic [rkg_pkg::CNT_W-1:0]  r_rem;
    logic [rkg_pkg::ADDR_W-1:0] r_idx;
    logic                       r_rev;
    logic                       r_last;
    logic                       r_lor;

    logic [rkg_pkg::CMP_W-1:0]  gs_ext;
    logic [rkg_pkg::CMP_W-1:0]  k_eff;
    logic [rkg_pkg::CMP_W-1:0]  fill_inc;
    logic                       grp_full;
    logic [rkg_pkg::VAL_W-1:0]  rd_data;

    always_comb begin
        gs_ext = rkg_pkg::CMP_W'(r_gs);
        if (gs_ext == '0) begin
            k_eff = rkg_pkg::CMP_W'(1);
        end else if (gs_ext > rkg_pkg::CMP_W'(rkg_pkg::MAX_GROUP)) begin
            k_eff = rkg_pkg::CMP_W'(rkg_pkg::MAX_GROUP);
        end else begin
            k_eff = gs_ext;
        end
        fill_inc = rkg_pkg::CMP_W'(r_fill) + rkg_pkg::CMP_W'(1);
        grp_full = (fill_inc >= k_eff);
    end

    assign o_status.emit    = grp_full | i_end_of_list;
    assign o_status.run_end = r_lor;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= rkg_pkg::GS_RESET;
            r_fill <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gs <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (grp_full || i_end_of_list) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= rkg_pkg::CNT_W'(fill_inc);
                end
            end
        end
    end

    // run sequencing; r_fill is the index of the value being written
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rev  <= grp_full;
            r_last <= i_end_of_list;
            r_rem  <= r_fill;
            r_idx  <= grp_full ? r_fill[rkg_pkg::ADDR_W-1:0] : '0;
        end else if (i_cmd.read) begin
            r_lor <= (r_rem == '0);
            r_rem <= r_rem - rkg_pkg::CNT_W'(1);
            r_idx <= r_rev ? (r_idx - rkg_pkg::ADDR_W'(1)) : (r_idx + rkg_pkg::ADDR_W'(1));
        end
    end

    rkg_ram #(
        .WIDTH (rkg_pkg::VAL_W),
        .DEPTH (rkg_pkg::MAX_GROUP)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_fill[rkg_pkg::ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.read),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign o_out_value   = signed'(rd_data);
    assign o_last_of_run = r_lor;
    assign o_list_done   = r_lor & r_last;
endmodule
